// ===== hdl/ptu_pkg.sv =====
// Shared types and constants of the two-level page table update engine.
// Holds the channel payload structs, the control enums and the controller/datapath link.
// No dependencies.
package ptu_pkg;

   localparam int TABLE_PAGES_DEF = 64;
   localparam int FRAME_W         = 20;
   localparam int ENTRY_IDX_W     = 10;
   localparam int ATTR_W          = 12;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [FRAME_W-1:0] WINDOW_BASE_RST = 20'd256;
   localparam logic [FRAME_W-1:0] POOL_START_RST  = 20'd256;
   localparam logic [FRAME_W-1:0] POOL_END_RST    = 20'd319;

   localparam logic [ATTR_W-1:0] PRESENT_BIT   = 12'h001;
   localparam logic [ATTR_W-1:0] CLEAR_PRESENT = 12'hffe;

   // command codes
   localparam logic CMD_MAP   = 1'b0;
   localparam logic CMD_UNMAP = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POOL_START  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POOL_END    = 2'd2;

   typedef struct packed {
      logic                command;
      logic [FRAME_W-1:0]  dir_frame;
      logic [31:0]         virt_address;
      logic [31:0]         phys_address;
      logic [ATTR_W-1:0]   attr_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_PDE_WAIT,
      S_ZERO,
      S_WR_PDE,
      S_WR_PTE,
      S_RD_PTE,
      S_PTE_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_ZERO,
      MEM_RD_PDE,
      MEM_WR_PDE,
      MEM_RD_PTE,
      MEM_WR_PTE,
      MEM_CLR_PTE
   } mem_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_DONE,
      RES_OUTSIDE,
      RES_EXHAUSTED,
      RES_FRAME
   } res_sel_type;

   typedef struct packed {
      mem_op_type  mem_op;
      res_sel_type res_sel;
      logic        load_req;
      logic        load_pde;
      logic        load_table;
      logic        take_frame;
      logic        cnt_clear;
      logic        cnt_inc;
      logic        rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_unmap;
      logic dir_ok;
      logic pde_present;
      logic pool_ok;
      logic tab_win;
      logic cnt_page_last;
      logic cnt_all_last;
   } dp_stat_type;

endpackage

// ===== hdl/ptu_datapath.sv =====
// Datapath of the page table update engine: table memory, request and
// pool registers, window checks and the result register.
// Depends on ptu_pkg.
module ptu_datapath #(
   parameter int TABLE_PAGES = ptu_pkg::TABLE_PAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptu_pkg::req_type                     req_data,
   output ptu_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [ptu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ptu_pkg::FRAME_W-1:0]          csr_data,
   input  ptu_pkg::dp_cmd_type                  cmd,
   output ptu_pkg::dp_stat_type                 stat
);

   localparam int FW    = ptu_pkg::FRAME_W;
   localparam int IW    = ptu_pkg::ENTRY_IDX_W;
   localparam int AT    = ptu_pkg::ATTR_W;
   localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int AW    = PW + IW;
   localparam int DEPTH = TABLE_PAGES * (2 ** IW);
   localparam logic [FW-1:0] PAGES_F   = FW'(TABLE_PAGES);
   localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

   logic [FW-1:0] base_ff, base_in;
   logic [FW-1:0] pend_ff, pend_in;
   logic [FW-1:0] next_ff, next_in;
   logic          empty_ff, empty_in;
   logic [AW-1:0] cnt_ff, cnt_in;

   logic          cmd_ff, cmd_in;
   logic [IW-1:0] dir_idx_ff, dir_idx_in;
   logic [IW-1:0] tab_idx_ff, tab_idx_in;
   logic [FW-1:0] phys_ff, phys_in;
   logic [AT-1:0] attr_ff, attr_in;
   logic [PW-1:0] dir_off_ff, dir_off_in;
   logic          dir_ok_ff, dir_ok_in;
   logic [31:0]   pde_ff, pde_in;
   logic [FW-1:0] table_ff, table_in;
   logic [PW-1:0] toff_ff, toff_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   ptu_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0]   rd_data_ff;
   logic [31:0]   mem [DEPTH];
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_wdata;
   logic          mem_we;

   logic [FW-1:0] dir_diff;
   logic [FW-1:0] tab_frame;
   logic [FW-1:0] tab_diff;
   logic          tab_win;

   // window checks
   always_comb begin
      dir_diff  = req_data.dir_frame - base_ff;
      tab_frame = rd_data_ff[0] ? rd_data_ff[31:12] : next_ff;
      tab_diff  = tab_frame - base_ff;
      tab_win   = (tab_frame >= base_ff) && (tab_diff < PAGES_F);
   end

   always_comb begin
      stat.is_unmap      = (cmd_ff == ptu_pkg::CMD_UNMAP);
      stat.dir_ok        = dir_ok_ff;
      stat.pde_present   = rd_data_ff[0];
      stat.pool_ok       = !empty_ff && (next_ff <= pend_ff);
      stat.tab_win       = tab_win;
      stat.cnt_page_last = (cnt_ff[IW-1:0] == {IW{1'b1}});
      stat.cnt_all_last  = (cnt_ff == LAST_WORD);
   end

   // memory port selection
   always_comb begin
      mem_addr  = '0;
      mem_wdata = '0;
      mem_we    = 1'b0;
      unique case (cmd.mem_op)
         ptu_pkg::MEM_CLEAR: begin
            mem_addr = cnt_ff;
            mem_we   = 1'b1;
         end
         ptu_pkg::MEM_ZERO: begin
            mem_addr = {toff_ff, cnt_ff[IW-1:0]};
            mem_we   = 1'b1;
         end
         ptu_pkg::MEM_RD_PDE: begin
            mem_addr = {dir_off_ff, dir_idx_ff};
         end
         ptu_pkg::MEM_WR_PDE: begin
            mem_addr  = {dir_off_ff, dir_idx_ff};
            mem_wdata = {table_ff, pde_ff[AT-1:0] | attr_ff | ptu_pkg::PRESENT_BIT};
            mem_we    = 1'b1;
         end
         ptu_pkg::MEM_RD_PTE: begin
            mem_addr = {toff_ff, tab_idx_ff};
         end
         ptu_pkg::MEM_WR_PTE: begin
            mem_addr  = {toff_ff, tab_idx_ff};
            mem_wdata = {phys_ff, attr_ff | ptu_pkg::PRESENT_BIT};
            mem_we    = 1'b1;
         end
         ptu_pkg::MEM_CLR_PTE: begin
            mem_addr  = {toff_ff, tab_idx_ff};
            mem_wdata = {rd_data_ff[31:12], rd_data_ff[AT-1:0] & ptu_pkg::CLEAR_PRESENT};
            mem_we    = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // next values
   always_comb begin
      base_in       = base_ff;
      pend_in       = pend_ff;
      next_in       = next_ff;
      empty_in      = empty_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      dir_idx_in    = dir_idx_ff;
      tab_idx_in    = tab_idx_ff;
      phys_in       = phys_ff;
      attr_in       = attr_ff;
      dir_off_in    = dir_off_ff;
      dir_ok_in     = dir_ok_ff;
      pde_in        = pde_ff;
      table_in      = table_ff;
      toff_in       = toff_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_write) begin
         unique case (csr_index)
            ptu_pkg::REG_WINDOW_BASE: base_in = csr_data;
            ptu_pkg::REG_POOL_START: begin
               next_in  = csr_data;
               empty_in = 1'b0;
            end
            ptu_pkg::REG_POOL_END: pend_in = csr_data;
            default: base_in = base_ff;
         endcase
      end

      if (cmd.take_frame) begin
         if (next_ff == pend_ff) begin
            empty_in = 1'b1;
         end else begin
            next_in = next_ff + 1'b1;
         end
      end

      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.load_req) begin
         cmd_in     = req_data.command;
         dir_idx_in = req_data.virt_address[31:22];
         tab_idx_in = req_data.virt_address[21:12];
         phys_in    = req_data.phys_address[31:12];
         attr_in    = req_data.attr_bits;
         dir_off_in = dir_diff[PW-1:0];
         dir_ok_in  = (req_data.dir_frame >= base_ff) && (dir_diff < PAGES_F);
      end

      if (cmd.load_pde) begin
         pde_in = rd_data_ff;
      end

      if (cmd.load_table) begin
         table_in = tab_frame;
         toff_in  = tab_diff[PW-1:0];
      end

      unique case (cmd.res_sel)
         ptu_pkg::RES_DONE: begin
            res_addr_in   = '0;
            res_status_in = ptu_pkg::STATUS_DONE;
         end
         ptu_pkg::RES_OUTSIDE: begin
            res_addr_in   = '0;
            res_status_in = ptu_pkg::STATUS_OUTSIDE;
         end
         ptu_pkg::RES_EXHAUSTED: begin
            res_addr_in   = '0;
            res_status_in = ptu_pkg::STATUS_EXHAUSTED;
         end
         ptu_pkg::RES_FRAME: begin
            res_addr_in   = {rd_data_ff[31:12], 12'h000};
            res_status_in = ptu_pkg::STATUS_DONE;
         end
         default: begin
            res_addr_in = res_addr_ff;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_data_in.result_address = res_addr_ff;
         rsp_data_in.status         = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= ptu_pkg::WINDOW_BASE_RST;
         pend_ff  <= ptu_pkg::POOL_END_RST;
         next_ff  <= ptu_pkg::POOL_START_RST;
         empty_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         base_ff  <= base_in;
         pend_ff  <= pend_in;
         next_ff  <= next_in;
         empty_ff <= empty_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      dir_idx_ff    <= dir_idx_in;
      tab_idx_ff    <= tab_idx_in;
      phys_ff       <= phys_in;
      attr_ff       <= attr_in;
      dir_off_ff    <= dir_off_in;
      dir_ok_ff     <= dir_ok_in;
      pde_ff        <= pde_in;
      table_ff      <= table_in;
      toff_ff       <= toff_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== hdl/ptu_ctrl.sv =====
// Controller of the page table update engine: sequences the clearing pass,
// the directory and table walk, table zeroing and the response handshake.
// Depends on ptu_pkg.
module ptu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ptu_pkg::dp_stat_type  stat,
   output ptu_pkg::dp_cmd_type   cmd
);

   ptu_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptu_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ptu_pkg::S_CLEAR: begin
            cmd.mem_op  = ptu_pkg::MEM_CLEAR;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_all_last) begin
               state_in = ptu_pkg::S_IDLE;
            end
         end
         ptu_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ptu_pkg::S_DIR;
            end
         end
         ptu_pkg::S_DIR: begin
            if (!stat.dir_ok) begin
               cmd.res_sel = ptu_pkg::RES_OUTSIDE;
               state_in    = ptu_pkg::S_RESP;
            end else begin
               cmd.mem_op = ptu_pkg::MEM_RD_PDE;
               state_in   = ptu_pkg::S_PDE_WAIT;
            end
         end
         ptu_pkg::S_PDE_WAIT: begin
            cmd.load_pde = 1'b1;
            priority if (stat.is_unmap && !stat.pde_present) begin
               cmd.res_sel = ptu_pkg::RES_FRAME;
               state_in    = ptu_pkg::S_RESP;
            end else if (!stat.is_unmap && !stat.pde_present && !stat.pool_ok) begin
               cmd.res_sel = ptu_pkg::RES_EXHAUSTED;
               state_in    = ptu_pkg::S_RESP;
            end else if (!stat.tab_win) begin
               cmd.res_sel = ptu_pkg::RES_OUTSIDE;
               state_in    = ptu_pkg::S_RESP;
            end else begin
               cmd.load_table = 1'b1;
               priority if (stat.is_unmap) begin
                  state_in = ptu_pkg::S_RD_PTE;
               end else if (!stat.pde_present) begin
                  // take a fresh table frame and zero it first
                  cmd.take_frame = 1'b1;
                  cmd.cnt_clear  = 1'b1;
                  state_in       = ptu_pkg::S_ZERO;
               end else begin
                  state_in = ptu_pkg::S_WR_PDE;
               end
            end
         end
         ptu_pkg::S_ZERO: begin
            cmd.mem_op  = ptu_pkg::MEM_ZERO;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_page_last) begin
               state_in = ptu_pkg::S_WR_PDE;
            end
         end
         ptu_pkg::S_WR_PDE: begin
            cmd.mem_op = ptu_pkg::MEM_WR_PDE;
            state_in   = ptu_pkg::S_WR_PTE;
         end
         ptu_pkg::S_WR_PTE: begin
            cmd.mem_op  = ptu_pkg::MEM_WR_PTE;
            cmd.res_sel = ptu_pkg::RES_DONE;
            state_in    = ptu_pkg::S_RESP;
         end
         ptu_pkg::S_RD_PTE: begin
            cmd.mem_op = ptu_pkg::MEM_RD_PTE;
            state_in   = ptu_pkg::S_PTE_WAIT;
         end
         ptu_pkg::S_PTE_WAIT: begin
            cmd.mem_op  = ptu_pkg::MEM_CLR_PTE;
            cmd.res_sel = ptu_pkg::RES_FRAME;
            state_in    = ptu_pkg::S_RESP;
         end
         ptu_pkg::S_RESP: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ptu_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptu_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transaction completed");

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptu_pkg::S_CLEAR && !stat.cnt_all_last) |=> state_ff == ptu_pkg::S_CLEAR)
      else $error("clearing pass left early");

   a_zero_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptu_pkg::S_ZERO && !stat.cnt_page_last) |=> state_ff == ptu_pkg::S_ZERO)
      else $error("table zeroing left early");

   a_take_needs_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.take_frame |-> (stat.pool_ok && stat.tab_win))
      else $error("table frame taken from an exhausted pool or outside window");
`endif

endmodule

// ===== hdl/two_level_page_table_update.sv =====
// Two-level page table update engine, top level.
// Each request is answered after a full walk, after first zeroing a new page table, from the
// directory entry alone, or with no memory read for a directory outside the window.
// One transaction at a time: req_ready stays low until the response has been loaded.
// Reset: synchronous; then a clearing pass over all TABLE_PAGES*1024 words zeroes the table memory
// while req_ready stays low; configuration writes are taken at any time.
module two_level_page_table_update #(
   parameter int TABLE_PAGES = ptu_pkg::TABLE_PAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ptu_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ptu_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ptu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ptu_pkg::FRAME_W-1:0]      csr_data
);

   ptu_pkg::dp_cmd_type  cmd;
   ptu_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   ptu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptu_datapath #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for two_level_page_table_update: directed and random map/unmap transactions
// checked field by field against a behavioral copy of the table memory and table pool.
// Depends on ptu_pkg and the two_level_page_table_update RTL.
module tb_top;

   localparam int TABLE_PAGES    = ptu_pkg::TABLE_PAGES_DEF;
   localparam int TABLE_WORDS    = TABLE_PAGES * 1024;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam logic [ptu_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_type;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   ptu_pkg::req_type                 req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   ptu_pkg::rsp_type                 rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ptu_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [ptu_pkg::FRAME_W-1:0]      csr_data  = '0;

   // shadow of the engine state
   bit [31:0]                   page_words [TABLE_WORDS];
   logic [ptu_pkg::FRAME_W-1:0] cfg_window_base = ptu_pkg::WINDOW_BASE_RST;
   logic [ptu_pkg::FRAME_W-1:0] cfg_pool_start  = ptu_pkg::POOL_START_RST;
   logic [ptu_pkg::FRAME_W-1:0] cfg_pool_end    = ptu_pkg::POOL_END_RST;
   logic [ptu_pkg::FRAME_W-1:0] alloc_frame     = ptu_pkg::POOL_START_RST;
   bit                          pool_drained    = 1'b0;

   ptu_pkg::rsp_type            pending_walk_results [$];
   ptu_pkg::req_type            recent_maps [$];
   ptu_pkg::rsp_type            oldest_result;
   logic [ptu_pkg::FRAME_W-1:0] home_dir = ptu_pkg::WINDOW_BASE_RST;

   int        errors          = 0;
   int        requests_sent   = 0;
   int        results_checked = 0;
   int        map_count       = 0;
   int        unmap_count     = 0;
   int        status_count [4];
   int        burst_left      = 0;
   int        quiet_cycles    = 0;
   int        cycle_count     = 0;
   bit        gaps_on         = 1'b1;
   stall_type stall_mode      = STALL_NONE;

   two_level_page_table_update #(
      .TABLE_PAGES(TABLE_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit frame_in_window(logic [ptu_pkg::FRAME_W-1:0] frame);
      return frame >= cfg_window_base &&
             (32'(frame) - 32'(cfg_window_base)) < TABLE_PAGES;
   endfunction

   function automatic int unsigned word_addr(logic [ptu_pkg::FRAME_W-1:0] frame,
                                             logic [9:0] entry);
      return (32'(frame) - 32'(cfg_window_base)) * 1024 + 32'(entry);
   endfunction

   // Walk the tables for one request, update the shadow and return the reply.
   function automatic ptu_pkg::rsp_type predict_page_walk(ptu_pkg::req_type rq);
      ptu_pkg::rsp_type            rs;
      logic [9:0]                  dir_idx;
      logic [9:0]                  tab_idx;
      logic [31:0]                 pde;
      logic [31:0]                 pte;
      logic [ptu_pkg::FRAME_W-1:0] table_frame;
      int unsigned                 pde_at;
      int unsigned                 pte_at;
      bit                          fresh;
      int                          i;
      rs.result_address = '0;
      rs.status         = ptu_pkg::STATUS_DONE;
      dir_idx           = rq.virt_address[31:22];
      tab_idx           = rq.virt_address[21:12];
      fresh             = 1'b0;
      if (!frame_in_window(rq.dir_frame)) begin
         rs.status = ptu_pkg::STATUS_OUTSIDE;
      end else begin
         pde_at = word_addr(rq.dir_frame, dir_idx);
         pde    = page_words[pde_at];
         if (rq.command == ptu_pkg::CMD_MAP) begin
            table_frame = pde[31:12];
            if (!pde[0]) begin
               if (pool_drained || alloc_frame > cfg_pool_end) begin
                  rs.status = ptu_pkg::STATUS_EXHAUSTED;
               end else begin
                  table_frame = alloc_frame;
                  fresh       = 1'b1;
               end
            end
            // the window check comes before any write, also for a new pool frame
            if (rs.status == ptu_pkg::STATUS_DONE && !frame_in_window(table_frame))
               rs.status = ptu_pkg::STATUS_OUTSIDE;
            if (rs.status == ptu_pkg::STATUS_DONE) begin
               if (fresh) begin
                  if (alloc_frame == cfg_pool_end)
                     pool_drained = 1'b1;
                  else
                     alloc_frame = alloc_frame + 1'b1;
                  for (i = 0; i < 1024; i++)
                     page_words[word_addr(table_frame, 10'(i))] = '0;
                  pde = {table_frame, pde[11:0]};
               end
               pde[11:0] = pde[11:0] | rq.attr_bits | ptu_pkg::PRESENT_BIT;
               page_words[pde_at] = pde;
               page_words[word_addr(table_frame, tab_idx)] =
                  {rq.phys_address[31:12], (rq.attr_bits | ptu_pkg::PRESENT_BIT)};
            end
         end else if (!pde[0]) begin
            rs.result_address = {pde[31:12], 12'h000};
         end else begin
            table_frame = pde[31:12];
            if (!frame_in_window(table_frame)) begin
               rs.status = ptu_pkg::STATUS_OUTSIDE;
            end else begin
               pte_at             = word_addr(table_frame, tab_idx);
               pte                = page_words[pte_at];
               pte[11:0]          = pte[11:0] & ptu_pkg::CLEAR_PRESENT;
               page_words[pte_at] = pte;
               rs.result_address  = {pte[31:12], 12'h000};
            end
         end
      end
      return rs;
   endfunction

   function automatic ptu_pkg::req_type make_request(logic cmd,
                                                     logic [ptu_pkg::FRAME_W-1:0] dir,
                                                     logic [31:0] va, logic [31:0] pa,
                                                     logic [ptu_pkg::ATTR_W-1:0] attrs);
      ptu_pkg::req_type rq;
      rq.command      = cmd;
      rq.dir_frame    = dir;
      rq.virt_address = va;
      rq.phys_address = pa;
      rq.attr_bits    = attrs;
      return rq;
   endfunction

   // Mostly walks through a few home directories with small directory indexes so tables
   // get reused; some in-window frames, some noise, and unmaps of recent mappings.
   function automatic ptu_pkg::req_type random_request();
      ptu_pkg::req_type rq;
      ptu_pkg::req_type pick;
      int unsigned      roll;
      roll            = $urandom_range(0, 99);
      rq.command      = ($urandom_range(0, 99) < 55) ? ptu_pkg::CMD_MAP : ptu_pkg::CMD_UNMAP;
      rq.phys_address = $urandom;
      rq.attr_bits    = 12'($urandom);
      rq.virt_address = {10'($urandom_range(0, 7)), 22'($urandom)};
      if (roll < 5) begin
         rq.command      = 1'($urandom);
         rq.dir_frame    = 20'($urandom);
         rq.virt_address = $urandom;
      end else if (roll < 15) begin
         rq.dir_frame = cfg_window_base + 20'($urandom_range(0, TABLE_PAGES - 1));
      end else begin
         rq.dir_frame = home_dir + 20'($urandom_range(0, 3));
         if (roll < 18)
            rq.virt_address[31:22] = 10'($urandom);
      end
      if (roll >= 5 && rq.command == ptu_pkg::CMD_UNMAP && recent_maps.size() != 0 &&
          $urandom_range(0, 2) != 0) begin
         pick            = recent_maps[$urandom_range(0, recent_maps.size() - 1)];
         rq.dir_frame    = pick.dir_frame;
         rq.virt_address = pick.virt_address;
      end
      if (rq.command == ptu_pkg::CMD_MAP) begin
         recent_maps.push_back(rq);
         if (recent_maps.size() > 32)
            void'(recent_maps.pop_front());
      end
      return rq;
   endfunction

   task automatic send_walk_request(input ptu_pkg::req_type rq);
      ptu_pkg::rsp_type expected;
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected = predict_page_walk(rq);
      pending_walk_results.push_back(expected);
      requests_sent++;
      status_count[expected.status]++;
      if (rq.command == ptu_pkg::CMD_MAP)
         map_count++;
      else
         unmap_count++;
   endtask

   // hold off until every outstanding transaction has been answered
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_walk_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [ptu_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [ptu_pkg::FRAME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         ptu_pkg::REG_WINDOW_BASE: cfg_window_base = value;
         ptu_pkg::REG_POOL_START: begin
            cfg_pool_start = value;
            alloc_frame    = value;
            pool_drained   = 1'b0;
         end
         ptu_pkg::REG_POOL_END: cfg_pool_end = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure_tables(input logic [ptu_pkg::FRAME_W-1:0] window_base,
                                   input logic [ptu_pkg::FRAME_W-1:0] pool_start,
                                   input logic [ptu_pkg::FRAME_W-1:0] pool_end,
                                   input logic [ptu_pkg::FRAME_W-1:0] first_dir);
      wait_for_results();
      write_register(ptu_pkg::REG_WINDOW_BASE, window_base);
      write_register(ptu_pkg::REG_POOL_END, pool_end);
      write_register(ptu_pkg::REG_POOL_START, pool_start);
      home_dir = first_dir;
      recent_maps.delete();
   endtask

   task automatic run_random_batch(input int count, input bit with_gaps, input int drain_at);
      int n;
      gaps_on = with_gaps;
      for (n = 0; n < count; n++) begin
         if (n == drain_at)
            wait_for_results();
         send_walk_request(random_request());
      end
   endtask

   // Reset configuration: window 256..319, pool 256..319, directory at frame 316.
   task automatic test_map_unmap_basics();
      logic [ptu_pkg::FRAME_W-1:0] dir;
      dir = 20'd316;
      // new tables at both ends of the directory, extreme addresses and attributes
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0000_0000, 32'h0000_0000,
                                     12'h000));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     12'hFFF));
      // unmap, then unmap the same entry again while already not present
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'hFFFF_F000, 32'h0, 12'h000));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'hFFFF_F000, 32'hFFFF_FFFF,
                                     12'hFFF));
      // unmap through an absent directory entry
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'h0040_0000, 32'h0, 12'h000));
      // directory outside the window
      send_walk_request(make_request(ptu_pkg::CMD_MAP, 20'h00000, 32'h1234_5678, 32'h0,
                                     12'h003));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, 20'hFFFFF, 32'h1234_5678, 32'h0,
                                     12'h000));
      // table 257 as directory: absent entry that still holds a frame
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, 20'd257, 32'hFFC0_0000, 32'h0,
                                     12'h000));
      // table 256 as directory: present entry linking frame 0, outside the window
      send_walk_request(make_request(ptu_pkg::CMD_MAP, 20'd256, 32'h0000_0000, 32'h0,
                                     12'h001));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, 20'd256, 32'h0000_0ABC, 32'h0,
                                     12'h000));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, 20'd256, 32'h0040_0000, 32'h5555_5000,
                                     12'h004));
      // existing table, low address bits ignored, attributes without present
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0000_1FFF, 32'h1234_5FFF,
                                     12'h006));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'h0000_1000, 32'h0, 12'h000));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h003F_F000, 32'hABCD_E000,
                                     12'h800));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'h003F_F123, 32'h0, 12'h000));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'hFFC0_0000, 32'h8000_0000,
                                     12'hAAA));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'hFFC0_0000, 32'h0, 12'h555));
   endtask

   task automatic test_pool_limits();
      logic [ptu_pkg::FRAME_W-1:0] dir;
      dir = 20'd310;
      // one-frame pool: first new table taken, next one exhausted
      configure_tables(ptu_pkg::WINDOW_BASE_RST, 20'd300, 20'd300, dir);
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0A00_0000, 32'h1111_1000,
                                     12'h002));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0A40_0000, 32'h2222_2000,
                                     12'h002));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0A00_5000, 32'h3333_3000,
                                     12'h004));
      // pool end below pool start
      configure_tables(ptu_pkg::WINDOW_BASE_RST, 20'd301, 20'h00000, dir);
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0A80_0000, 32'h4444_4000,
                                     12'h000));
      // pool frame outside the window is refused and not taken
      configure_tables(ptu_pkg::WINDOW_BASE_RST, 20'h01000, 20'h01FFF, dir);
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0AC0_0000, 32'h5555_5000,
                                     12'h001));
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0AC0_1000, 32'h5555_6000,
                                     12'h001));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'h0AC0_0000, 32'h0, 12'h000));
      // next pool frame is the directory itself
      configure_tables(ptu_pkg::WINDOW_BASE_RST, dir, ptu_pkg::POOL_END_RST, dir);
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0B00_7000, 32'h6666_6000,
                                     12'h006));
      send_walk_request(make_request(ptu_pkg::CMD_UNMAP, dir, 32'h0B00_7000, 32'h0, 12'h000));
      // unused register index must leave the pool alone
      wait_for_results();
      write_register(REG_UNUSED, 20'hFFFFF);
      send_walk_request(make_request(ptu_pkg::CMD_MAP, dir, 32'h0B40_0000, 32'h7777_7000,
                                     12'h001));
   endtask

   task automatic test_random_walks();
      configure_tables(ptu_pkg::WINDOW_BASE_RST, 20'd264, ptu_pkg::POOL_END_RST,
                       ptu_pkg::WINDOW_BASE_RST);
      run_random_batch(300, 1'b1, 150);
      configure_tables(20'h80000, 20'h80004, 20'h8003F, 20'h80000);
      run_random_batch(120, 1'b0, -1);
   endtask

   task automatic test_window_extremes();
      // pool from frame 0 to the top: runs past the window and the directory is frame 0
      configure_tables(20'h00000, 20'h00000, 20'hFFFFF, 20'h00000);
      run_random_batch(150, 1'b1, -1);
      configure_tables(20'hFFFC0, 20'hFFFC8, 20'hFFFFF, 20'hFFFC0);
      run_random_batch(150, 1'b1, 75);
      configure_tables(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      run_random_batch(40, 1'b0, -1);
   endtask

   // compare each reply with the oldest expectation, then drive the stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_walk_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none, got address %h status %0d",
                     $time, rsp_data.result_address, rsp_data.status);
         end else begin
            oldest_result = pending_walk_results.pop_front();
            if (rsp_data.result_address !== oldest_result.result_address) begin
               errors++;
               $display("%0t: result_address expected %h got %h", $time,
                        oldest_result.result_address, rsp_data.result_address);
            end
            if (rsp_data.status !== oldest_result.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time,
                        oldest_result.status, rsp_data.status);
            end
         end
      end
      cycle_count++;
      if (cycle_count % 200 == 0)
         stall_mode = stall_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_ready <= 1'b1;
         STALL_LIGHT:    rsp_ready <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_ready <= ((cycle_count % 9) < 3);
         default:        rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_map_unmap_basics();
      test_pool_limits();
      test_random_walks();
      test_window_extremes();
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (%0d map, %0d unmap), checked %0d replies, %0d errors",
               requests_sent, map_count, unmap_count, results_checked, errors);
      $display("Replies: %0d done, %0d table outside window, %0d pool exhausted",
               status_count[ptu_pkg::STATUS_DONE], status_count[ptu_pkg::STATUS_OUTSIDE],
               status_count[ptu_pkg::STATUS_EXHAUSTED]);
      if (errors == 0 && pending_walk_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
